FILE: rtl/core/pwt_pkg.sv
// Shared types and constants of the phone whitelist table.
// Used by pwt_ctrl, pwt_datapath and phone_whitelist_table_unit; no dependencies.
package pwt_pkg;

  localparam int unsigned KeyW = 60;
  localparam int unsigned LenW = 4;
  localparam logic [LenW-1:0] MinDigits = 4'd8;
  localparam logic [LenW-1:0] KeyDigits = 4'd15;

  typedef enum logic [2:0] {
    CMD_ADD       = 3'd0,
    CMD_REMOVE    = 3'd1,
    CMD_LOOKUP    = 3'd2,
    CMD_SET_ADMIN = 3'd3,
    CMD_READ_SLOT = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_EXISTS    = 2'd1,
    STAT_FULL      = 2'd2,
    STAT_NOT_FOUND = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_SCAN,
    S_DRAIN,
    S_READ,
    S_FINISH
  } state_e;

  typedef struct packed {
    logic [KeyW-1:0] key;
    logic [LenW-1:0] len;
    logic            admin;
  } mem_word_t;

  typedef struct packed {
    logic capture;
    logic scan_clear;
    logic scan_issue;
    logic read_issue;
    logic finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic need_scan;
    logic need_read;
    logic scan_last;
  } dp_status_t;

endpackage

FILE: rtl/core/pwt_ctrl.sv
// Controller state machine of the phone whitelist table.
// Depends on pwt_pkg for the state, command and status types.
module pwt_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  pwt_pkg::dp_status_t  status_i,
  output pwt_pkg::ctrl_cmd_t   cmd_o
);

  pwt_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pwt_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    busy    = 1'b1;
    unique case (state_q)
      pwt_pkg::S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd_o.capture = 1'b1;
          state_d       = pwt_pkg::S_DISPATCH;
        end
      end
      pwt_pkg::S_DISPATCH: begin
        cmd_o.scan_clear = 1'b1;
        priority if (status_i.need_scan) begin
          state_d = pwt_pkg::S_SCAN;
        end else if (status_i.need_read) begin
          state_d = pwt_pkg::S_READ;
        end else begin
          state_d = pwt_pkg::S_FINISH;
        end
      end
      pwt_pkg::S_SCAN: begin
        cmd_o.scan_issue = 1'b1;
        if (status_i.scan_last) begin
          state_d = pwt_pkg::S_DRAIN;
        end
      end
      pwt_pkg::S_DRAIN: begin
        state_d = pwt_pkg::S_FINISH;
      end
      pwt_pkg::S_READ: begin
        cmd_o.read_issue = 1'b1;
        state_d          = pwt_pkg::S_FINISH;
      end
      pwt_pkg::S_FINISH: begin
        cmd_o.finish = 1'b1;
        state_d      = pwt_pkg::S_IDLE;
      end
      default: begin
        state_d = pwt_pkg::S_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/core/pwt_datapath.sv
// Datapath of the phone whitelist table: slot memory, valid bits, scan compare,
// counters and result registers. Depends on pwt_pkg; driven by pwt_ctrl.
module pwt_datapath #(
  parameter int unsigned ENTRIES = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  pwt_pkg::ctrl_cmd_t   cmd_i,
  output pwt_pkg::dp_status_t  status_o,
  input  logic [2:0]           command_i,
  input  logic [27:0]          key_upper_i,
  input  logic [31:0]          key_lower_i,
  input  logic [3:0]           key_length_i,
  input  logic                 admin_value_i,
  input  logic [7:0]           slot_index_i,
  output logic                 result_valid_o,
  output logic [1:0]           res_status_o,
  output logic                 found_o,
  output logic                 entry_admin_o,
  output logic [27:0]          entry_key_upper_o,
  output logic [31:0]          entry_key_lower_o,
  output logic [3:0]           entry_length_o,
  output logic [7:0]           slot_used_o,
  output logic [8:0]           entry_count_o,
  output logic [8:0]           admin_count_o
);

  localparam int unsigned IdxW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CntW = $clog2(ENTRIES + 1);

  logic [2:0]                cmd_q;
  logic [pwt_pkg::KeyW-1:0]  key_q;
  logic [pwt_pkg::LenW-1:0]  len_q;
  logic                      adm_q;
  logic [7:0]                idx_q;

  pwt_pkg::mem_word_t        mem_q [ENTRIES];
  pwt_pkg::mem_word_t        rd_q;
  pwt_pkg::mem_word_t        wr_data;
  logic                      wr_en;
  logic [IdxW-1:0]           wr_addr;
  logic [IdxW-1:0]           rd_addr;

  logic [ENTRIES-1:0]        valid_q, valid_d;
  logic [CntW-1:0]           vcnt_q, vcnt_d;
  logic [CntW-1:0]           acnt_q, acnt_d;

  logic [IdxW-1:0]           scan_q;
  logic [IdxW-1:0]           cmp_idx_q;
  logic                      cmp_en_q;
  logic                      hit_q;
  logic [IdxW-1:0]           hit_idx_q;
  logic                      hit_admin_q;
  logic                      free_q;
  logic [IdxW-1:0]           free_idx_q;
  logic                      match;
  logic                      is_free;

  logic                      len_ok;
  logic                      in_range;
  logic                      rd_valid;

  logic                      res_vld_q;
  logic [1:0]                res_status_q, res_status_d;
  logic                      res_found_q, res_found_d;
  logic                      res_admin_q, res_admin_d;
  logic [27:0]               res_upper_q, res_upper_d;
  logic [31:0]               res_lower_q, res_lower_d;
  logic [3:0]                res_len_q, res_len_d;
  logic [7:0]                res_slot_q, res_slot_d;

  assign len_ok   = (len_q >= pwt_pkg::MinDigits) && (len_q <= pwt_pkg::KeyDigits);
  assign in_range = ({1'b0, idx_q} < 9'(ENTRIES));
  assign rd_valid = in_range && valid_q[idx_q[IdxW-1:0]];
  assign rd_addr  = cmd_i.scan_issue ? scan_q : idx_q[IdxW-1:0];

  assign status_o.need_scan = (cmd_q <= pwt_pkg::CMD_SET_ADMIN) && len_ok;
  assign status_o.need_read = (cmd_q == pwt_pkg::CMD_READ_SLOT);
  assign status_o.scan_last = (scan_q == IdxW'(ENTRIES - 1));

  assign match   = cmp_en_q && valid_q[cmp_idx_q] && (rd_q.key == key_q) && (rd_q.len == len_q);
  assign is_free = cmp_en_q && !valid_q[cmp_idx_q];

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      cmd_q <= command_i;
      key_q <= {key_upper_i, key_lower_i};
      len_q <= key_length_i;
      adm_q <= admin_value_i;
      idx_q <= slot_index_i;
    end
    if (cmd_i.scan_issue || cmd_i.read_issue) begin
      rd_q <= mem_q[rd_addr];
    end
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    cmp_idx_q <= scan_q;
    if (match && !hit_q) begin
      hit_idx_q   <= cmp_idx_q;
      hit_admin_q <= rd_q.admin;
    end
    if (is_free && !free_q) begin
      free_idx_q <= cmp_idx_q;
    end
    if (cmd_i.finish) begin
      res_status_q <= res_status_d;
      res_found_q  <= res_found_d;
      res_admin_q  <= res_admin_d;
      res_upper_q  <= res_upper_d;
      res_lower_q  <= res_lower_d;
      res_len_q    <= res_len_d;
      res_slot_q   <= res_slot_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q   <= '0;
      vcnt_q    <= '0;
      acnt_q    <= '0;
      scan_q    <= '0;
      cmp_en_q  <= 1'b0;
      hit_q     <= 1'b0;
      free_q    <= 1'b0;
      res_vld_q <= 1'b0;
    end else begin
      valid_q   <= valid_d;
      vcnt_q    <= vcnt_d;
      acnt_q    <= acnt_d;
      res_vld_q <= cmd_i.finish;
      cmp_en_q  <= cmd_i.scan_issue;
      if (cmd_i.scan_clear) begin
        scan_q <= '0;
        hit_q  <= 1'b0;
        free_q <= 1'b0;
      end else begin
        if (cmd_i.scan_issue) begin
          scan_q <= scan_q + 1'b1;
        end
        if (match) begin
          hit_q <= 1'b1;
        end
        if (is_free) begin
          free_q <= 1'b1;
        end
      end
    end
  end

  always_comb begin
    logic first_admin;
    first_admin  = (vcnt_q == '0);
    valid_d      = valid_q;
    vcnt_d       = vcnt_q;
    acnt_d       = acnt_q;
    wr_en        = 1'b0;
    wr_addr      = hit_idx_q;
    wr_data      = '{key: key_q, len: len_q, admin: adm_q};
    res_status_d = pwt_pkg::STAT_OK;
    res_found_d  = 1'b0;
    res_admin_d  = 1'b0;
    res_upper_d  = '0;
    res_lower_d  = '0;
    res_len_d    = '0;
    res_slot_d   = '0;
    if (cmd_i.finish) begin
      if ((cmd_q <= pwt_pkg::CMD_SET_ADMIN) && !len_ok) begin
        res_status_d = pwt_pkg::STAT_NOT_FOUND;
      end else begin
        unique case (cmd_q)
          pwt_pkg::CMD_ADD: begin
            if (hit_q) begin
              res_status_d = pwt_pkg::STAT_EXISTS;
              res_slot_d   = 8'(hit_idx_q);
            end else if (free_q) begin
              wr_en               = 1'b1;
              wr_addr             = free_idx_q;
              wr_data.admin       = first_admin;
              valid_d[free_idx_q] = 1'b1;
              vcnt_d              = vcnt_q + 1'b1;
              acnt_d              = acnt_q + CntW'(first_admin);
              res_admin_d         = first_admin;
              res_slot_d          = 8'(free_idx_q);
            end else begin
              res_status_d = pwt_pkg::STAT_FULL;
            end
          end
          pwt_pkg::CMD_REMOVE: begin
            if (hit_q) begin
              valid_d[hit_idx_q] = 1'b0;
              vcnt_d             = vcnt_q - 1'b1;
              acnt_d             = acnt_q - CntW'(hit_admin_q);
              res_slot_d         = 8'(hit_idx_q);
            end else begin
              res_status_d = pwt_pkg::STAT_NOT_FOUND;
            end
          end
          pwt_pkg::CMD_LOOKUP: begin
            if (hit_q) begin
              res_found_d = 1'b1;
              res_admin_d = hit_admin_q;
              res_slot_d  = 8'(hit_idx_q);
            end else begin
              res_status_d = pwt_pkg::STAT_NOT_FOUND;
            end
          end
          pwt_pkg::CMD_SET_ADMIN: begin
            if (hit_q) begin
              wr_en       = 1'b1;
              acnt_d      = acnt_q + CntW'(adm_q) - CntW'(hit_admin_q);
              res_admin_d = adm_q;
              res_slot_d  = 8'(hit_idx_q);
            end else begin
              res_status_d = pwt_pkg::STAT_NOT_FOUND;
            end
          end
          pwt_pkg::CMD_READ_SLOT: begin
            if (rd_valid) begin
              res_found_d = 1'b1;
              res_admin_d = rd_q.admin;
              res_upper_d = rd_q.key[59:32];
              res_lower_d = rd_q.key[31:0];
              res_len_d   = rd_q.len;
              res_slot_d  = idx_q;
            end else begin
              res_status_d = pwt_pkg::STAT_NOT_FOUND;
            end
          end
          default: begin
            res_status_d = pwt_pkg::STAT_OK;
          end
        endcase
      end
    end
  end

  assign result_valid_o    = res_vld_q;
  assign res_status_o      = res_status_q;
  assign found_o           = res_found_q;
  assign entry_admin_o     = res_admin_q;
  assign entry_key_upper_o = res_upper_q;
  assign entry_key_lower_o = res_lower_q;
  assign entry_length_o    = res_len_q;
  assign slot_used_o       = res_slot_q;
  assign entry_count_o     = 9'(vcnt_q);
  assign admin_count_o     = 9'(acnt_q);

endmodule

FILE: rtl/core/phone_whitelist_table_unit.sv
// Top level of the phone whitelist table: controller plus datapath.
// Depends on pwt_pkg, pwt_ctrl and pwt_datapath.
//
// A command is taken when start is high and busy is low. Every command first
// passes a dispatch state. Add, remove, lookup and set admin with a valid key
// length then scan every slot through the single read port of the slot
// memory, one slot a cycle, and pass a drain state and a finish state; read
// slot passes a read state and a finish state; a scanning command with a bad
// key length, or a command with an unknown code, goes straight to the finish
// state. The result appears on the result ports for exactly one cycle with
// result_valid_o high, in the cycle in which busy falls, and must be captured
// then: the receiver cannot stall the block. The next command can be taken at
// the end of that same cycle. entry_count_o and admin_count_o hold the
// current totals at all times. The table is empty right after reset.
module phone_whitelist_table_unit #(
  parameter int unsigned ENTRIES = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  command_i,
  input  logic [27:0] key_upper_i,
  input  logic [31:0] key_lower_i,
  input  logic [3:0]  key_length_i,
  input  logic        admin_value_i,
  input  logic [7:0]  slot_index_i,
  output logic        result_valid_o,
  output logic [1:0]  status_o,
  output logic        found_o,
  output logic        entry_admin_o,
  output logic [27:0] entry_key_upper_o,
  output logic [31:0] entry_key_lower_o,
  output logic [3:0]  entry_length_o,
  output logic [7:0]  slot_used_o,
  output logic [8:0]  entry_count_o,
  output logic [8:0]  admin_count_o
);

  pwt_pkg::ctrl_cmd_t  ctrl_cmd;
  pwt_pkg::dp_status_t dp_status;

  pwt_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .status_i (dp_status),
    .cmd_o    (ctrl_cmd)
  );

  pwt_datapath #(
    .ENTRIES (ENTRIES)
  ) u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (ctrl_cmd),
    .status_o          (dp_status),
    .command_i         (command_i),
    .key_upper_i       (key_upper_i),
    .key_lower_i       (key_lower_i),
    .key_length_i      (key_length_i),
    .admin_value_i     (admin_value_i),
    .slot_index_i      (slot_index_i),
    .result_valid_o    (result_valid_o),
    .res_status_o      (status_o),
    .found_o           (found_o),
    .entry_admin_o     (entry_admin_o),
    .entry_key_upper_o (entry_key_upper_o),
    .entry_key_lower_o (entry_key_lower_o),
    .entry_length_o    (entry_length_o),
    .slot_used_o       (slot_used_o),
    .entry_count_o     (entry_count_o),
    .admin_count_o     (admin_count_o)
  );

endmodule
